// ----- rtl/fwcfg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: shared package
// Types, constants and codes used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package fwcfg_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_BYTES = 512;
  localparam int BEAT_BYTES = 8;
  localparam int MAX_BEATS  = 64;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int OFF_W      = $clog2(SLOT_BYTES);
  localparam int POS_W      = 10;
  localparam int MEM_DEPTH  = NUM_SLOTS * SLOT_BYTES;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int CNT_W      = 4;

  typedef enum logic [2:0] {
    CMD_SELECT = 3'd0,
    CMD_READ   = 3'd1,
    CMD_DMA    = 3'd2,
    CMD_LOAD   = 3'd3,
    CMD_SET    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PORT = 2'd0,
    KIND_BEAT = 2'd1,
    KIND_ACK  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_FETCH,
    ST_EMIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] key;
    logic [3:0]  read_bytes;
    logic [31:0] dma_control;
    logic [31:0] dma_length;
    logic [63:0] target_addr;
    logic [3:0]  slot;
    logic [8:0]  byte_offset;
    logic [7:0]  byte_value;
    logic [9:0]  entry_size;
    logic        entry_valid;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data;
    logic [3:0]  byte_count;
    logic [63:0] write_address;
    logic        last;
    logic        error;
  } out_word_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;     // latch input word, apply select / stores
    logic decide;      // compute transfer totals after lookup
    logic fetch_start; // clear byte assembly for a new word
    logic fetch_byte;  // read one byte at the current pointer
    logic emit;        // load output register from assembly
    logic emit_ack;    // load output register with an acknowledge
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] command;
    logic       found;
    logic       dma_read;
    logic       xfer_zero;
    logic       word_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/fwcfg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: channel interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface fwcfg_in_if;
  import fwcfg_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fwcfg_out_if;
  import fwcfg_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/fwcfg_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: controller
// Sequences lookup, byte fetch and result emission for one word at a time.
// ----------------------------------------------------------------------------
module fwcfg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                out_busy,
  input  wire logic                out_last,
  input  wire fwcfg_pkg::dp_stat_t stat,
  output fwcfg_pkg::dp_cmd_t       cmd
);
  import fwcfg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (stat.command == CMD_READ && stat.found) begin
          state_nxt = ST_FETCH;
        end else if (stat.command == CMD_DMA && stat.found && stat.dma_read &&
                     !stat.xfer_zero) begin
          state_nxt = ST_FETCH;
        end else if (!out_busy) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_FETCH: begin
        if (stat.word_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_busy) state_nxt = out_last ? ST_WAIT : ST_FETCH;
      end
      ST_WAIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: cmd.decide = 1'b1;
      ST_DECIDE: begin
        if ((stat.command == CMD_READ && stat.found) ||
            (stat.command == CMD_DMA && stat.found && stat.dma_read && !stat.xfer_zero)) begin
          cmd.fetch_start = 1'b1;
        end else if (!out_busy) begin
          cmd.emit_ack = 1'b1;
        end
      end
      ST_FETCH: cmd.fetch_byte = 1'b1;
      ST_EMIT: begin
        if (!out_busy) begin
          cmd.emit        = 1'b1;
          cmd.fetch_start = !out_last;
        end
      end
      ST_WAIT: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/fwcfg_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: datapath
// Slot table, entry byte store, position tracking and result assembly.
// ----------------------------------------------------------------------------
module fwcfg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fwcfg_pkg::in_word_t in_word,
  input  wire fwcfg_pkg::dp_cmd_t  cmd,
  output fwcfg_pkg::dp_stat_t      stat,
  output fwcfg_pkg::out_word_t     res,
  output logic                     res_last
);
  import fwcfg_pkg::*;

  in_word_t               w_r;
  logic [15:0]            cur_key_r;
  logic [POS_W-1:0]       pos_r;
  logic [15:0]            keys_r [NUM_SLOTS];
  logic [POS_W-1:0]       sizes_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   present_r;
  logic [7:0]             mem [MEM_DEPTH];
  logic [7:0]             rd_r;
  logic                   rd_v_r;

  logic                   found_r;
  logic [SLOT_W-1:0]      hit_r;
  logic [POS_W-1:0]       size_r;
  logic [POS_W-1:0]       total_r;   // bytes to move for this word
  logic [POS_W-1:0]       sent_r;    // dma bytes already emitted
  logic [CNT_W-1:0]       want_r;    // bytes in the current output word
  logic [CNT_W-1:0]       got_r;     // bytes requested from the store
  logic [CNT_W-1:0]       asm_n_r;   // bytes assembled
  logic [63:0]            asm_r;
  logic                   word_last_r;

  logic [15:0]            key_eff;
  logic                   hit_any;
  logic [SLOT_W-1:0]      hit_idx;
  logic [POS_W-1:0]       avail;
  logic [POS_W-1:0]       sent_eff;
  logic [POS_W-1:0]       beat_n;
  logic [CNT_W-1:0]       rd_n;
  logic                   rd_issue;

  assign key_eff = cur_key_r;

  // Priority lookup: lowest present slot with the matching key wins.
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (present_r[s] && keys_r[s] == key_eff) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(s);
      end
    end
  end

  // A beat set up while the previous one is emitted counts that one as sent.
  assign sent_eff = cmd.emit ? sent_r + POS_W'(want_r) : sent_r;
  assign avail  = (pos_r < sizes_r[hit_idx]) ? sizes_r[hit_idx] - pos_r : '0;
  assign rd_n   = (w_r.read_bytes > CNT_W'(8)) ? CNT_W'(8) : w_r.read_bytes;
  assign beat_n = (total_r - sent_eff > POS_W'(BEAT_BYTES)) ? POS_W'(BEAT_BYTES)
                                                            : total_r - sent_eff;
  assign rd_issue = cmd.fetch_byte && (got_r < want_r) &&
                    (w_r.command == CMD_DMA || pos_r < size_r);

  // Slot table and select handling.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_key_r <= '0;
      present_r <= '0;
    end else if (cmd.capture) begin
      if (in_word.command == CMD_SELECT) begin
        cur_key_r <= in_word.key;
      end else if (in_word.command == CMD_DMA && in_word.dma_control[3]) begin
        cur_key_r <= in_word.dma_control[31:16];
      end else if (in_word.command == CMD_SET) begin
        present_r[in_word.slot[SLOT_W-1:0]] <= in_word.entry_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && in_word.command == CMD_SET) begin
      keys_r[in_word.slot[SLOT_W-1:0]]  <= in_word.key;
      sizes_r[in_word.slot[SLOT_W-1:0]] <= (in_word.entry_size > POS_W'(SLOT_BYTES)) ?
                                           POS_W'(SLOT_BYTES) : in_word.entry_size;
    end
  end

  // Entry store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.capture && in_word.command == CMD_LOAD) begin
      mem[{in_word.slot[SLOT_W-1:0], in_word.byte_offset[OFF_W-1:0]}] <= in_word.byte_value;
    end
    rd_r <= mem[{hit_r, pos_r[OFF_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) w_r <= in_word;
    if (cmd.decide) begin
      found_r <= hit_any;
      hit_r   <= hit_idx;
      size_r  <= sizes_r[hit_idx];
      sent_r  <= '0;
      if (w_r.command == CMD_READ) begin
        total_r <= POS_W'(rd_n);
      end else begin
        total_r <= (avail > POS_W'(w_r.dma_length) && w_r.dma_length < 32'(MAX_BEATS*BEAT_BYTES))
                   ? POS_W'(w_r.dma_length)
                   : ((avail > POS_W'(MAX_BEATS*BEAT_BYTES)) ? POS_W'(MAX_BEATS*BEAT_BYTES)
                                                             : avail);
      end
    end else if (cmd.emit && w_r.command == CMD_DMA) begin
      sent_r <= sent_r + POS_W'(want_r);
    end
  end

  // Byte fetch: issue reads while a byte is wanted, gather each in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= rd_issue;
      if (cmd.capture && (in_word.command == CMD_SELECT ||
                          (in_word.command == CMD_DMA && in_word.dma_control[3]))) begin
        pos_r <= '0;
      end else if (rd_issue) begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_start) begin
      got_r       <= '0;
      asm_n_r     <= '0;
      asm_r       <= '0;
      if (w_r.command == CMD_READ) begin
        want_r      <= rd_n;
        word_last_r <= 1'b1;
      end else begin
        want_r      <= CNT_W'(beat_n);
        word_last_r <= (sent_eff + beat_n >= total_r);
      end
    end else if (cmd.fetch_byte) begin
      if (got_r < want_r) got_r <= got_r + CNT_W'(1);
      if (rd_v_r) begin
        asm_r[8*asm_n_r[2:0] +: 8] <= rd_r;
      end
      // Bytes past the end of a port read count as zero bytes.
      if (rd_v_r || (got_r > asm_n_r && !rd_v_r && w_r.command == CMD_READ)) begin
        asm_n_r <= asm_n_r + CNT_W'(1);
      end
    end
  end

  // A zero-length word or one whose bytes are all gathered is done.
  assign stat.word_done = (asm_n_r == want_r) && (got_r == want_r) && !rd_v_r;
  assign stat.command   = w_r.command;
  assign stat.found     = found_r;
  assign stat.dma_read  = w_r.dma_control[1];
  assign stat.xfer_zero = (total_r == '0);

  // The controller looks at the last mark of the word being assembled.
  assign res_last = word_last_r;

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      res.kind          <= (w_r.command == CMD_READ) ? KIND_PORT : KIND_ACK;
      res.data          <= '0;
      res.byte_count    <= (w_r.command == CMD_READ) ? rd_n : '0;
      res.write_address <= '0;
      res.last          <= 1'b1;
      res.error         <= (w_r.command == CMD_READ || w_r.command == CMD_DMA) &&
                           (!found_r || (w_r.command == CMD_DMA && !w_r.dma_control[1] &&
                                         w_r.dma_control[4]));
    end else if (cmd.emit) begin
      res.kind          <= (w_r.command == CMD_READ) ? KIND_PORT : KIND_BEAT;
      res.data          <= asm_r;
      res.byte_count    <= want_r;
      res.write_address <= (w_r.command == CMD_READ) ? 64'd0 :
                           w_r.target_addr + 64'(sent_r);
      res.last          <= word_last_r;
      res.error         <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/firmware_config_entry_port.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: top level
// Keyed entry table with a byte-wide data port and a beat-wide DMA reader.
// ----------------------------------------------------------------------------
// Select, load, set, unknown and acknowledge-only words present a single result
// word. A port read presents one port word; a DMA read of T bytes presents its
// bytes in beats, fetched byte by byte as the entry store has a single read
// port. The next word is accepted only after the final result; stalls delay
// it. Synchronous reset clears the current key, position and presence marks.
module firmware_config_entry_port (
  input wire logic      clk,
  input wire logic      rst_n,
  fwcfg_in_if.sink      in_ch,
  fwcfg_out_if.source   out_ch
);
  import fwcfg_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_word_t res;
  logic      res_last;
  logic      out_valid_r;
  logic      in_ready_c;

  assign in_ch.ready = in_ready_c;

  fwcfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready_c),
    .out_busy (out_valid_r && !out_ch.ready),
    .out_last (res_last),
    .stat     (stat),
    .cmd      (cmd)
  );

  fwcfg_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch.payload),
    .cmd      (cmd),
    .stat     (stat),
    .res      (res),
    .res_last (res_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = res;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(cmd.emit || cmd.emit_ack))
    else $error("result overwritten while stalled");

  a_single_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.emit_ack))
    else $error("two result sources at once");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready_c) |=> !in_ready_c)
    else $error("second word accepted while busy");

endmodule
`default_nettype wire

// ----- tb/firmware_config_entry_port_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Firmware configuration entry port: testbench
// A short table of directed words covers the reset state, missing entries,
// saturating counts, slot priority and every DMA status case. Random
// load / set / select / read sequences follow. Every result word is checked,
// against its directed expectation or an in-bench model of the entry table,
// with random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module firmware_config_entry_port_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fwcfg_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RAND_ITEMS  = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  fwcfg_in_if  in_ch();
  fwcfg_out_if out_ch();

  firmware_config_entry_port dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t result;
  } stim_row_t;

  stim_row_t stim_q[$];
  out_word_t pending_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        result_idx = 0;
  bit        all_sent = 1'b0;

  // Model of the entry table.
  logic [15:0] cur_key;
  logic [9:0]  cur_pos;
  logic [15:0] tbl_key [NUM_SLOTS];
  logic        tbl_live [NUM_SLOTS];
  logic [9:0]  tbl_size [NUM_SLOTS];
  logic [7:0]  tbl_bytes [MEM_DEPTH];

  // Loaded prefix per slot, used only to keep present entries readable.
  int loaded_len [NUM_SLOTS];
  logic [15:0] key_pool [4];

  function automatic out_word_t mk(kind_t k, logic [63:0] d, int cnt, logic [63:0] a,
                                   logic l, logic e);
    out_word_t o;
    o.kind = k;
    o.data = d;
    o.byte_count = cnt[3:0];
    o.write_address = a;
    o.last = l;
    o.error = e;
    return o;
  endfunction

  function automatic int lookup_slot();
    for (int s = 0; s < NUM_SLOTS; s++)
      if (tbl_live[s] && tbl_key[s] == cur_key) return s;
    return -1;
  endfunction

  function automatic void predict_results(in_word_t w, ref out_word_t res[$]);
    int s, n, total, base, nb;
    logic [63:0] d;
    res = {};
    case (w.command)
      CMD_SELECT: begin
        cur_key = w.key;
        cur_pos = '0;
        res.push_back(mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b0));
      end
      CMD_READ: begin
        s = lookup_slot();
        n = (w.read_bytes > 8) ? 8 : int'(w.read_bytes);
        d = '0;
        if (s < 0) begin
          res.push_back(mk(KIND_PORT, 0, n, 0, 1'b1, 1'b1));
        end else begin
          for (int i = 0; i < n; i++)
            if (cur_pos < tbl_size[s]) begin
              d |= 64'(tbl_bytes[s * SLOT_BYTES + cur_pos]) << (8 * i);
              cur_pos++;
            end
          res.push_back(mk(KIND_PORT, d, n, 0, 1'b1, 1'b0));
        end
      end
      CMD_DMA: begin
        if (w.dma_control[3]) begin
          cur_key = w.dma_control[31:16];
          cur_pos = '0;
        end
        s = lookup_slot();
        if (s < 0) begin
          res.push_back(mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b1));
        end else if (w.dma_control[1]) begin
          total = (cur_pos < tbl_size[s]) ? int'(tbl_size[s]) - int'(cur_pos) : 0;
          if (longint'(total) > longint'(w.dma_length)) total = int'(w.dma_length);
          if (total > MAX_BEATS * BEAT_BYTES) total = MAX_BEATS * BEAT_BYTES;
          base = s * SLOT_BYTES;
          if (total == 0) begin
            res.push_back(mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b0));
          end else begin
            for (int b = 0; b < total; b += nb) begin
              nb = (total - b > BEAT_BYTES) ? BEAT_BYTES : total - b;
              d = '0;
              for (int i = 0; i < nb; i++)
                d |= 64'(tbl_bytes[base + cur_pos + b + i]) << (8 * i);
              res.push_back(mk(KIND_BEAT, d, nb, w.target_addr + 64'(b),
                               (b + nb >= total), 1'b0));
            end
            cur_pos += 10'(total);
          end
        end else begin
          res.push_back(mk(KIND_ACK, 0, 0, 0, 1'b1, w.dma_control[4]));
        end
      end
      default: begin
        if (w.command == CMD_LOAD)
          tbl_bytes[w.slot * SLOT_BYTES + w.byte_offset] = w.byte_value;
        else if (w.command == CMD_SET) begin
          tbl_key[w.slot]  = w.key;
          tbl_size[w.slot] = (w.entry_size > SLOT_BYTES) ? 10'(SLOT_BYTES) : w.entry_size;
          tbl_live[w.slot] = w.entry_valid;
        end
        res.push_back(mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b0));
      end
    endcase
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("result %0d: %s got %h want %h", result_idx, field, got, want);
    errors++;
  endtask

  task automatic check_word(out_word_t got, out_word_t want);
    if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
    if (got.data != want.data) report("data", got.data, want.data);
    if (got.byte_count != want.byte_count)
      report("byte_count", 64'(got.byte_count), 64'(want.byte_count));
    if (got.write_address != want.write_address)
      report("write_address", got.write_address, want.write_address);
    if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
    if (got.error != want.error) report("error", 64'(got.error), 64'(want.error));
  endtask

  // Every field random, so that unused fields toggle too.
  function automatic in_word_t rand_word(logic [2:0] cmd);
    in_word_t w;
    w.command     = cmd;
    w.key         = 16'($urandom);
    w.read_bytes  = 4'($urandom);
    w.dma_control = $urandom;
    w.dma_length  = $urandom;
    w.target_addr = {$urandom, $urandom};
    w.slot        = 4'($urandom);
    w.byte_offset = 9'($urandom);
    w.byte_value  = 8'($urandom);
    w.entry_size  = 10'($urandom);
    w.entry_valid = 1'($urandom);
    return w;
  endfunction

  task automatic add(in_word_t w, bit typed = 1'b0, out_word_t r = '0);
    stim_row_t row;
    row.word = w;
    row.typed = typed;
    row.result = r;
    stim_q.push_back(row);
  endtask

  function automatic in_word_t w_load(int s, int off, int val);
    in_word_t w = rand_word(CMD_LOAD);
    w.slot = 4'(s);
    w.byte_offset = 9'(off);
    w.byte_value = 8'(val);
    return w;
  endfunction

  function automatic in_word_t w_set(int s, logic [15:0] k, int sz, bit v);
    in_word_t w = rand_word(CMD_SET);
    w.slot = 4'(s);
    w.key = k;
    w.entry_size = 10'(sz);
    w.entry_valid = v;
    return w;
  endfunction

  function automatic in_word_t w_dma(logic [31:0] ctl, logic [31:0] len);
    in_word_t w = rand_word(CMD_DMA);
    w.dma_control = ctl;
    w.dma_length = len;
    return w;
  endfunction

  task automatic build_directed();
    in_word_t w;
    out_word_t ack = mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b0);
    w = rand_word(CMD_SELECT); w.key = 16'h0000;
    add(w, 1'b1, ack);
    // Nothing is present after reset: reads flag a missing entry.
    w = rand_word(CMD_READ); w.read_bytes = 4'd15;
    add(w, 1'b1, mk(KIND_PORT, 0, 8, 0, 1'b1, 1'b1));
    w = rand_word(CMD_READ); w.read_bytes = 4'd0;
    add(w, 1'b1, mk(KIND_PORT, 0, 0, 0, 1'b1, 1'b1));
    add(w_dma(32'h0000_0002, 32'hFFFF_FFFF), 1'b1, mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b1));
    add(rand_word(3'd7), 1'b1, ack);
    add(w_set(15, 16'h0000, 1023, 1'b0), 1'b1, ack);
    add(w_set(14, 16'hFFFF, 512, 1'b0), 1'b1, ack);
    for (int i = 0; i < 8; i++)
      add(w_load(1, i, (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'(i * 37 + 5)), 1'b1, ack);
    loaded_len[1] = 8;
    // Two present slots share a key; the lower one is empty.
    add(w_set(0, 16'hFFFF, 0, 1'b1), 1'b1, ack);
    add(w_set(1, 16'hFFFF, 8, 1'b1), 1'b1, ack);
    w = rand_word(CMD_SELECT); w.key = 16'hFFFF;
    add(w, 1'b1, ack);
    w = rand_word(CMD_READ); w.read_bytes = 4'd8;
    add(w);
    add(w_set(0, 16'hFFFF, 0, 1'b0), 1'b1, ack);
    add(w_dma(32'h0000_0002, 32'd3));
    add(w);
    add(w_dma(32'hFFFF_000A, 32'hFFFF_FFFF));
    add(w_dma(32'h0000_0010, 32'd8), 1'b1, mk(KIND_ACK, 0, 0, 0, 1'b1, 1'b1));
    add(w_dma(32'hFFFF_001A, 32'd8));
    add(w_dma(32'h0000_0000, 32'd8), 1'b1, ack);
    // Shrink the entry below the read position: reads give zeros.
    add(w_set(1, 16'hFFFF, 2, 1'b1), 1'b1, ack);
    add(w);
    add(w_dma(32'h0000_0002, 32'd16));
  endtask

  task automatic build_random();
    in_word_t w;
    int r, s, n, sz, made;
    logic [31:0] ctl;
    made = 0;
    while (made < RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        case ($urandom_range(0, 3))
          0: w = rand_word(3'($urandom_range(5, 7)));
          1: w = w_set($urandom_range(0, 15), 16'($urandom), $urandom_range(0, 1023), 1'b0);
          2: w = w_dma(($urandom & ~32'h2) | 32'h10, $urandom);
          default: w = rand_word(CMD_READ);
        endcase
        add(w);
        made++;
      end else if (r < 45) begin
        // Load a prefix of a slot, then declare it present.
        s = $urandom_range(0, 15);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 24);
        for (int i = loaded_len[s]; i < n; i++) begin
          add(w_load(s, i, $urandom_range(0, 255)));
          made++;
        end
        if (n > loaded_len[s]) loaded_len[s] = n;
        if ($urandom_range(0, 3) == 0) begin
          add(w_load(s, $urandom_range(0, 511), $urandom_range(0, 255)));
          made++;
        end
        sz = ($urandom_range(0, 2) == 0) ? loaded_len[s] : $urandom_range(0, loaded_len[s]);
        add(w_set(s, key_pool[$urandom_range(0, 3)], sz, 1'b1));
        made++;
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          w = rand_word(CMD_SELECT);
          w.key = key_pool[$urandom_range(0, 3)];
          add(w);
          made++;
        end
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          if ($urandom_range(0, 1) == 0) begin
            w = rand_word(CMD_READ);
          end else begin
            ctl = $urandom | 32'h2;
            if ($urandom_range(0, 1) == 0) ctl[31:16] = key_pool[$urandom_range(0, 3)];
            w = w_dma(ctl, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 70));
          end
          add(w);
          made++;
        end
      end
    end
  endtask

  // Sender: bursts of words with random gaps between them.
  initial begin
    int burst, idx;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h1234;
    key_pool[3] = 16'($urandom);
    for (int s = 0; s < NUM_SLOTS; s++) loaded_len[s] = 0;
    build_directed();
    build_random();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && idx < stim_q.size()) begin
        in_ch.valid   <= 1'b1;
        in_ch.payload <= stim_q[idx].word;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        idx++;
        burst--;
      end
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    all_sent <= 1'b1;
  end

  // Receiver: the stall pattern is redrawn at random, plus one long hold-off.
  initial begin
    int mode;
    out_ch.ready <= 1'b0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (cycles == 3000) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom);
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: predict on each accepted input word, check each result word.
  initial begin
    int idx;
    out_word_t res[$];
    out_word_t want;
    idx = 0;
    forever begin
      @(posedge clk);
      if (rst_n && in_ch.valid && in_ch.ready) begin
        predict_results(in_ch.payload, res);
        if (stim_q[idx].typed) pending_q.push_back(stim_q[idx].result);
        else foreach (res[i]) pending_q.push_back(res[i]);
        idx++;
      end
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_q.size() == 0) begin
          report("unexpected word", out_ch.payload.data, 64'd0);
        end else begin
          want = pending_q.pop_front();
          check_word(out_ch.payload, want);
        end
        result_idx++;
      end
    end
  end

  initial begin
    cur_key = '0;
    cur_pos = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      tbl_key[s] = '0;
      tbl_live[s] = 1'b0;
      tbl_size[s] = '0;
    end
    for (int i = 0; i < MEM_DEPTH; i++) tbl_bytes[i] = '0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("firmware_config_entry_port_tb: done, errors");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    while (!(all_sent && pending_q.size() == 0)) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("firmware_config_entry_port_tb: done, clean");
    end else begin
      $display("firmware_config_entry_port_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
